// ----- hw/rtl/qsf_pkg.sv -----
// Shared types, constants and the solve microprogram for the quadric surface fit unit.
package qsf_pkg;

    localparam int COORD_W        = 14;
    localparam int SQ_W           = 2 * COORD_W;
    localparam int P4_W           = 2 * SQ_W;
    localparam int P3_W           = SQ_W + COORD_W;
    localparam int SUM4_W         = 62;
    localparam int SUM3_W         = 48;
    localparam int MAX_POINTS_DEF = 64;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W         = $clog2(QDEPTH + 1);
    localparam int WIDE_W         = 200;
    localparam int FRAC_SHIFT     = 28;
    localparam int QBITS          = 34;
    localparam int DIV_W          = WIDE_W + QBITS + 2;
    localparam int COEF_W         = 32;
    localparam int UOP_N          = 24;
    localparam int PC_W           = 5;
    localparam int STEP_W         = 6;

    // One patch worth of moment sums plus its dropped-point flag.
    typedef struct packed {
        logic signed [SUM4_W-1:0] s4x;
        logic signed [SUM4_W-1:0] s3xy;
        logic signed [SUM4_W-1:0] s22;
        logic signed [SUM4_W-1:0] s13;
        logic signed [SUM4_W-1:0] s4y;
        logic signed [SUM3_W-1:0] s2xz;
        logic signed [SUM3_W-1:0] sxyz;
        logic signed [SUM3_W-1:0] s2yz;
        logic                     ovf;
    } t_moments;

    // Moment sum selector: A..E are the fourth-order sums, P/Q/S the z sums.
    typedef enum logic [2:0] {
        S_A = 3'd0, S_B = 3'd1, S_C = 3'd2, S_D = 3'd3,
        S_E = 3'd4, S_P = 3'd5, S_Q = 3'd6, S_S = 3'd7
    } t_ssel;

    // Multiplicand selector: any sum or one of the wide temporaries.
    typedef enum logic [3:0] {
        W_A   = 4'd0,  W_B   = 4'd1,  W_C   = 4'd2,  W_D  = 4'd3,
        W_E   = 4'd4,  W_P   = 4'd5,  W_Q   = 4'd6,  W_S  = 4'd7,
        W_CDE = 4'd8,  W_BCD = 4'd9,  W_BDC = 4'd10, W_T  = 4'd11,
        W_T2  = 4'd12, W_U   = 4'd13
    } t_wsel;

    typedef enum logic [3:0] {
        D_CDE = 4'd0, D_BCD = 4'd1, D_BDC = 4'd2, D_DET = 4'd3, D_T  = 4'd4,
        D_T2  = 4'd5, D_U   = 4'd6, D_NA  = 4'd7, D_NB  = 4'd8, D_NC = 4'd9
    } t_dsel;

    typedef enum logic [1:0] {
        MOP_SET = 2'd0, MOP_ADD = 2'd1, MOP_SUB = 2'd2, MOP_NEG = 2'd3
    } t_mop;

    typedef struct packed {
        t_wsel mcand;
        t_ssel mplier;
        t_dsel dst;
        t_mop  op;
    } t_uop;

    // Cramer's rule as a multiply/accumulate program.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        begin
            case (pc)
                5'd0:    u = '{W_C,   S_E, D_CDE, MOP_SET};
                5'd1:    u = '{W_D,   S_D, D_CDE, MOP_SUB};
                5'd2:    u = '{W_B,   S_E, D_BCD, MOP_SET};
                5'd3:    u = '{W_C,   S_D, D_BCD, MOP_SUB};
                5'd4:    u = '{W_B,   S_D, D_BDC, MOP_SET};
                5'd5:    u = '{W_C,   S_C, D_BDC, MOP_SUB};
                5'd6:    u = '{W_CDE, S_A, D_DET, MOP_SET};
                5'd7:    u = '{W_BCD, S_B, D_DET, MOP_SUB};
                5'd8:    u = '{W_BDC, S_C, D_DET, MOP_ADD};
                5'd9:    u = '{W_Q,   S_E, D_T,   MOP_SET};
                5'd10:   u = '{W_S,   S_D, D_T,   MOP_SUB};
                5'd11:   u = '{W_Q,   S_D, D_T2,  MOP_SET};
                5'd12:   u = '{W_S,   S_C, D_T2,  MOP_SUB};
                5'd13:   u = '{W_S,   S_B, D_U,   MOP_SET};
                5'd14:   u = '{W_Q,   S_C, D_U,   MOP_SUB};
                5'd15:   u = '{W_CDE, S_P, D_NA,  MOP_SET};
                5'd16:   u = '{W_T,   S_B, D_NA,  MOP_SUB};
                5'd17:   u = '{W_T2,  S_C, D_NA,  MOP_ADD};
                5'd18:   u = '{W_T,   S_A, D_NB,  MOP_SET};
                5'd19:   u = '{W_BCD, S_P, D_NB,  MOP_SUB};
                5'd20:   u = '{W_U,   S_C, D_NB,  MOP_ADD};
                5'd21:   u = '{W_T2,  S_A, D_NC,  MOP_NEG};
                5'd22:   u = '{W_U,   S_B, D_NC,  MOP_SUB};
                5'd23:   u = '{W_BDC, S_P, D_NC,  MOP_ADD};
                default: u = '{W_C,   S_E, D_CDE, MOP_SET};
            endcase
            return u;
        end
    endfunction

    // Sign-extended read of one moment sum.
    function automatic logic signed [SUM4_W-1:0] get_sum(input t_moments m, input t_ssel s);
        logic signed [SUM4_W-1:0] v;
        begin
            unique case (s)
                S_A:     v = m.s4x;
                S_B:     v = m.s3xy;
                S_C:     v = m.s22;
                S_D:     v = m.s13;
                S_E:     v = m.s4y;
                S_P:     v = SUM4_W'($signed(m.s2xz));
                S_Q:     v = SUM4_W'($signed(m.sxyz));
                S_S:     v = SUM4_W'($signed(m.s2yz));
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- hw/rtl/qsf_front.sv -----
// Front end: point intake, count/overflow tracking and moment accumulation pipeline.
module qsf_front #(
    parameter int MAX_POINTS = qsf_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [qsf_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [qsf_pkg::COORD_W-1:0]  i_y_coord,
    input  logic signed [qsf_pkg::COORD_W-1:0]  i_z_coord,
    input  logic                                i_last_point,
    input  logic [qsf_pkg::QCNT_W-1:0]          i_q_count,
    output logic                                o_push,
    output qsf_pkg::t_moments                   o_push_data
);

    localparam int CntW = $clog2(MAX_POINTS + 1);
    localparam int SQ   = qsf_pkg::SQ_W;
    localparam int P4   = qsf_pkg::P4_W;
    localparam int P3   = qsf_pkg::P3_W;
    localparam int S4   = qsf_pkg::SUM4_W;
    localparam int S3   = qsf_pkg::SUM3_W;

    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic            w_acc, w_use;

    // stage 1: squares and cross product
    logic                 r_s1_v, r_s1_last, r_s1_use, r_s1_ovf;
    logic signed [SQ-1:0] r_s1_x2, r_s1_xy, r_s1_y2;
    logic signed [qsf_pkg::COORD_W-1:0] r_s1_z;

    // stage 2: fourth and third order products
    logic                 r_s2_v, r_s2_last, r_s2_use, r_s2_ovf;
    logic signed [P4-1:0] r_p4x, r_p3xy, r_p22, r_p13, r_p4y;
    logic signed [P3-1:0] r_pxz, r_pxyz, r_pyz;

    qsf_pkg::t_moments r_sum, w_new;

    logic [qsf_pkg::QCNT_W+1:0] w_pending;

    assign w_pending = (qsf_pkg::QCNT_W+2)'(i_q_count)
                     + (qsf_pkg::QCNT_W+2)'(r_s1_v && r_s1_last)
                     + (qsf_pkg::QCNT_W+2)'(r_s2_v && r_s2_last);
    assign o_stall = (w_pending >= (qsf_pkg::QCNT_W+2)'(qsf_pkg::QDEPTH));
    assign w_acc   = i_valid && !o_stall;
    assign w_use   = (r_cnt < CntW'(MAX_POINTS));

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (w_acc) begin
            if (i_last_point) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else if (w_use) begin
                n_cnt = r_cnt + CntW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // sums including the point in stage 2
    always_comb begin
        w_new      = r_sum;
        w_new.ovf  = r_s2_ovf;
        if (r_s2_use) begin
            w_new.s4x  = r_sum.s4x  + S4'(r_p4x);
            w_new.s3xy = r_sum.s3xy + S4'(r_p3xy);
            w_new.s22  = r_sum.s22  + S4'(r_p22);
            w_new.s13  = r_sum.s13  + S4'(r_p13);
            w_new.s4y  = r_sum.s4y  + S4'(r_p4y);
            w_new.s2xz = r_sum.s2xz + S3'(r_pxz);
            w_new.sxyz = r_sum.sxyz + S3'(r_pxyz);
            w_new.s2yz = r_sum.s2yz + S3'(r_pyz);
        end
    end

    assign o_push      = r_s2_v && r_s2_last;
    assign o_push_data = w_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_sum  <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            r_s1_v <= w_acc;
            r_s2_v <= r_s1_v;
            if (r_s2_v) begin
                if (r_s2_last) begin
                    r_sum <= '0;
                end else begin
                    r_sum <= w_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_last <= i_last_point;
            r_s1_use  <= w_use;
            r_s1_ovf  <= r_ovf || !w_use;
            r_s1_x2   <= SQ'(i_x_coord) * SQ'(i_x_coord);
            r_s1_xy   <= SQ'(i_x_coord) * SQ'(i_y_coord);
            r_s1_y2   <= SQ'(i_y_coord) * SQ'(i_y_coord);
            r_s1_z    <= i_z_coord;
        end
        if (r_s1_v) begin
            r_s2_last <= r_s1_last;
            r_s2_use  <= r_s1_use;
            r_s2_ovf  <= r_s1_ovf;
            r_p4x     <= P4'(r_s1_x2) * P4'(r_s1_x2);
            r_p3xy    <= P4'(r_s1_x2) * P4'(r_s1_xy);
            r_p22     <= P4'(r_s1_xy) * P4'(r_s1_xy);
            r_p13     <= P4'(r_s1_xy) * P4'(r_s1_y2);
            r_p4y     <= P4'(r_s1_y2) * P4'(r_s1_y2);
            r_pxz     <= P3'(r_s1_x2) * P3'(r_s1_z);
            r_pxyz    <= P3'(r_s1_xy) * P3'(r_s1_z);
            r_pyz     <= P3'(r_s1_y2) * P3'(r_s1_z);
        end
    end

endmodule

// ----- hw/rtl/qsf_queue.sv -----
// Short queue of finished moment sets between the front end and the solver.
module qsf_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  qsf_pkg::t_moments           i_data,
    input  logic                        i_pop,
    output qsf_pkg::t_moments           o_data,
    output logic                        o_nonempty,
    output logic [qsf_pkg::QCNT_W-1:0]  o_count
);

    qsf_pkg::t_moments                r_mem [qsf_pkg::QDEPTH];
    logic [qsf_pkg::QPTR_W-1:0]       r_wp, r_rp;
    logic [qsf_pkg::QCNT_W-1:0]       r_cnt;
    logic                             w_pop;

    assign o_data     = r_mem[r_rp];
    assign o_nonempty = (r_cnt != '0);
    assign o_count    = r_cnt;
    assign w_pop      = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == qsf_pkg::QPTR_W'(qsf_pkg::QDEPTH - 1)) ? '0
                      : r_wp + qsf_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == qsf_pkg::QPTR_W'(qsf_pkg::QDEPTH - 1)) ? '0
                      : r_rp + qsf_pkg::QPTR_W'(1);
            end
            r_cnt <= r_cnt + qsf_pkg::QCNT_W'(i_push) - qsf_pkg::QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/qsf_solve.sv -----
// Back end: sequenced Cramer solve with a serial multiplier and a restoring divider.
module qsf_solve (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_nonempty,
    input  qsf_pkg::t_moments                  i_q_data,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [qsf_pkg::COEF_W-1:0]  o_coef_a,
    output logic signed [qsf_pkg::COEF_W-1:0]  o_coef_b,
    output logic signed [qsf_pkg::COEF_W-1:0]  o_coef_c,
    output logic                               o_singular,
    output logic                               o_too_many_points
);

    localparam int W  = qsf_pkg::WIDE_W;
    localparam int DW = qsf_pkg::DIV_W;
    localparam int QB = qsf_pkg::QBITS;
    localparam int CW = qsf_pkg::COEF_W;
    localparam int SW = qsf_pkg::STEP_W;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_LOAD  = 10'b0000000010,
        ST_MUL   = 10'b0000000100,
        ST_ACC   = 10'b0000001000,
        ST_CHECK = 10'b0000010000,
        ST_DPREP = 10'b0000100000,
        ST_DCMP  = 10'b0001000000,
        ST_DIV   = 10'b0010000000,
        ST_DFIN  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    t_state r_st, n_st;
    logic [qsf_pkg::PC_W-1:0] r_pc, n_pc;
    logic [SW-1:0]            r_k, n_k;
    logic [1:0]               r_ci, n_ci;
    logic                     r_o_valid, n_o_valid;

    qsf_pkg::t_moments r_mom, n_mom;
    logic signed [W-1:0] r_cde, r_bcd, r_bdc, r_det, r_t, r_t2, r_u, r_na, r_nb, r_nc;
    logic signed [W-1:0] n_cde, n_bcd, n_bdc, n_det, n_t, n_t2, n_u, n_na, n_nb, n_nc;
    logic signed [W-1:0] r_mcand, n_mcand, r_acc, n_acc;
    logic [qsf_pkg::SUM4_W-1:0] r_mplier, n_mplier;
    logic [W-1:0]  r_dabs, n_dabs;
    logic [DW-1:0] r_rem, n_rem, r_dsh, n_dsh;
    logic [QB-1:0] r_q, n_q;
    logic          r_neg, n_neg, r_sat, n_sat, r_sing, n_sing;
    logic signed [CW-1:0] r_ca, n_ca, r_cb, n_cb, r_cc, n_cc;
    logic signed [CW-1:0] r_oa, n_oa, r_ob, n_ob, r_oc, n_oc;
    logic r_osing, n_osing, r_oovf, n_oovf;

    qsf_pkg::t_uop       w_uop;
    logic signed [W-1:0] w_sel, w_dst, w_comb, w_n, w_term;
    logic [W-1:0]        w_nabs;
    logic [QB-1:0]       w_lim, w_mag;
    logic signed [CW-1:0] w_coef;
    logic                w_ge;

    assign w_uop = qsf_pkg::uop_rom(r_pc);

    // multiplicand source
    always_comb begin
        case (w_uop.mcand)
            qsf_pkg::W_CDE: w_sel = r_cde;
            qsf_pkg::W_BCD: w_sel = r_bcd;
            qsf_pkg::W_BDC: w_sel = r_bdc;
            qsf_pkg::W_T:   w_sel = r_t;
            qsf_pkg::W_T2:  w_sel = r_t2;
            qsf_pkg::W_U:   w_sel = r_u;
            default:        w_sel = W'(qsf_pkg::get_sum(r_mom,
                                       qsf_pkg::t_ssel'(w_uop.mcand[2:0])));
        endcase
    end

    always_comb begin
        case (w_uop.dst)
            qsf_pkg::D_CDE: w_dst = r_cde;
            qsf_pkg::D_BCD: w_dst = r_bcd;
            qsf_pkg::D_BDC: w_dst = r_bdc;
            qsf_pkg::D_DET: w_dst = r_det;
            qsf_pkg::D_T:   w_dst = r_t;
            qsf_pkg::D_T2:  w_dst = r_t2;
            qsf_pkg::D_U:   w_dst = r_u;
            qsf_pkg::D_NA:  w_dst = r_na;
            qsf_pkg::D_NB:  w_dst = r_nb;
            default:        w_dst = r_nc;
        endcase
    end

    always_comb begin
        case (w_uop.op)
            qsf_pkg::MOP_ADD: w_comb = w_dst + r_acc;
            qsf_pkg::MOP_SUB: w_comb = w_dst - r_acc;
            qsf_pkg::MOP_NEG: w_comb = -r_acc;
            default:          w_comb = r_acc;
        endcase
    end

    // MSB first; the top multiplier bit carries negative weight
    assign w_term = !r_mplier[qsf_pkg::SUM4_W-1] ? '0
                  : (r_k == SW'(qsf_pkg::SUM4_W - 1)) ? -r_mcand : r_mcand;

    always_comb begin
        case (r_ci)
            2'd0:    w_n = r_na;
            2'd1:    w_n = r_nb;
            default: w_n = r_nc;
        endcase
    end
    assign w_nabs = w_n[W-1] ? W'(-w_n) : W'(w_n);
    assign w_ge   = (r_rem >= r_dsh);
    assign w_lim  = r_neg ? (QB'(1) << (CW - 1)) : ((QB'(1) << (CW - 1)) - QB'(1));
    assign w_mag  = (r_sat || (r_q > w_lim)) ? w_lim : r_q;
    assign w_coef = r_neg ? CW'(-w_mag) : CW'(w_mag);

    assign o_pop = (r_st == ST_IDLE) && i_q_nonempty;

    always_comb begin
        n_st = r_st; n_pc = r_pc; n_k = r_k; n_ci = r_ci;
        n_o_valid = r_o_valid && i_stall;
        n_mom = r_mom;
        n_cde = r_cde; n_bcd = r_bcd; n_bdc = r_bdc; n_det = r_det; n_t = r_t;
        n_t2 = r_t2; n_u = r_u; n_na = r_na; n_nb = r_nb; n_nc = r_nc;
        n_mcand = r_mcand; n_acc = r_acc; n_mplier = r_mplier;
        n_dabs = r_dabs; n_rem = r_rem; n_dsh = r_dsh; n_q = r_q;
        n_neg = r_neg; n_sat = r_sat; n_sing = r_sing;
        n_ca = r_ca; n_cb = r_cb; n_cc = r_cc;
        n_oa = r_oa; n_ob = r_ob; n_oc = r_oc; n_osing = r_osing; n_oovf = r_oovf;
        unique case (r_st)
            ST_IDLE: begin
                if (i_q_nonempty) begin
                    n_mom = i_q_data;
                    n_pc  = '0;
                    n_st  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_mcand  = w_sel;
                n_mplier = qsf_pkg::get_sum(r_mom, w_uop.mplier);
                n_acc    = '0;
                n_k      = SW'(qsf_pkg::SUM4_W - 1);
                n_st     = ST_MUL;
            end
            ST_MUL: begin
                n_acc    = (r_acc <<< 1) + w_term;
                n_mplier = r_mplier << 1;
                if (r_k == '0) begin
                    n_st = ST_ACC;
                end else begin
                    n_k = r_k - SW'(1);
                end
            end
            ST_ACC: begin
                case (w_uop.dst)
                    qsf_pkg::D_CDE: n_cde = w_comb;
                    qsf_pkg::D_BCD: n_bcd = w_comb;
                    qsf_pkg::D_BDC: n_bdc = w_comb;
                    qsf_pkg::D_DET: n_det = w_comb;
                    qsf_pkg::D_T:   n_t   = w_comb;
                    qsf_pkg::D_T2:  n_t2  = w_comb;
                    qsf_pkg::D_U:   n_u   = w_comb;
                    qsf_pkg::D_NA:  n_na  = w_comb;
                    qsf_pkg::D_NB:  n_nb  = w_comb;
                    default:        n_nc  = w_comb;
                endcase
                if (r_pc == qsf_pkg::PC_W'(qsf_pkg::UOP_N - 1)) begin
                    n_st = ST_CHECK;
                end else begin
                    n_pc = r_pc + qsf_pkg::PC_W'(1);
                    n_st = ST_LOAD;
                end
            end
            ST_CHECK: begin
                n_sing = (r_det == '0);
                n_dabs = r_det[W-1] ? W'(-r_det) : W'(r_det);
                n_ci   = '0;
                n_st   = (r_det == '0) ? ST_OUT : ST_DPREP;
            end
            ST_DPREP: begin
                // rounded |n|*2^28/|d| = floor((2|n|*2^28 + |d|) / (2|d|))
                n_rem = (DW'(w_nabs) << (qsf_pkg::FRAC_SHIFT + 1)) + DW'(r_dabs);
                n_dsh = DW'(r_dabs) << (QB + 1);
                n_neg = (w_n[W-1] ^ r_det[W-1]) && (w_n != '0);
                n_st  = ST_DCMP;
            end
            ST_DCMP: begin
                n_sat = w_ge;
                n_dsh = r_dsh >> 1;
                n_q   = '0;
                n_k   = SW'(QB - 1);
                n_st  = ST_DIV;
            end
            ST_DIV: begin
                if (w_ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = {r_q[QB-2:0], w_ge};
                n_dsh = r_dsh >> 1;
                if (r_k == '0) begin
                    n_st = ST_DFIN;
                end else begin
                    n_k = r_k - SW'(1);
                end
            end
            ST_DFIN: begin
                case (r_ci)
                    2'd0:    n_ca = w_coef;
                    2'd1:    n_cb = w_coef;
                    default: n_cc = w_coef;
                endcase
                if (r_ci == 2'd2) begin
                    n_st = ST_OUT;
                end else begin
                    n_ci = r_ci + 2'd1;
                    n_st = ST_DPREP;
                end
            end
            ST_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_oa      = r_sing ? '0 : r_ca;
                    n_ob      = r_sing ? '0 : r_cb;
                    n_oc      = r_sing ? '0 : r_cc;
                    n_osing   = r_sing;
                    n_oovf    = r_mom.ovf;
                    n_st      = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_pc      <= '0;
            r_k       <= '0;
            r_ci      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_pc      <= n_pc;
            r_k       <= n_k;
            r_ci      <= n_ci;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mom <= n_mom;
        r_cde <= n_cde; r_bcd <= n_bcd; r_bdc <= n_bdc; r_det <= n_det; r_t <= n_t;
        r_t2 <= n_t2; r_u <= n_u; r_na <= n_na; r_nb <= n_nb; r_nc <= n_nc;
        r_mcand <= n_mcand; r_acc <= n_acc; r_mplier <= n_mplier;
        r_dabs <= n_dabs; r_rem <= n_rem; r_dsh <= n_dsh; r_q <= n_q;
        r_neg <= n_neg; r_sat <= n_sat; r_sing <= n_sing;
        r_ca <= n_ca; r_cb <= n_cb; r_cc <= n_cc;
        r_oa <= n_oa; r_ob <= n_ob; r_oc <= n_oc; r_osing <= n_osing; r_oovf <= n_oovf;
    end

    assign o_valid           = r_o_valid;
    assign o_coef_a          = r_oa;
    assign o_coef_b          = r_ob;
    assign o_coef_c          = r_oc;
    assign o_singular        = r_osing;
    assign o_too_many_points = r_oovf;

endmodule

// ----- hw/rtl/quadric_surface_fit_unit.sv -----
// Top level of the quadric surface fit unit: front end, queue and solver.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  points  | in        | i_valid / o_stall  | i_x_coord, i_y_coord, i_z_coord, i_last_point
//  result  | out       | o_valid / i_stall  | o_coef_a/b/c, o_singular, o_too_many_points
//
// Points are taken one per cycle while o_stall is low; a three-stage pipeline
// forms the products and adds them into the eight moment sums. A request
// marked last hands the sums to a two-entry queue and clears them for the
// next patch. The solver runs one patch at a time: 24 serial multiplies on
// the one-bit-per-cycle multiplier plus three divisions. o_stall rises only
// when the queue (counting last points still in the pipeline) is full.
// Reset is synchronous, active low.
module quadric_surface_fit_unit #(
    parameter int MAX_POINTS = qsf_pkg::MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [qsf_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [qsf_pkg::COORD_W-1:0] i_y_coord,
    input  logic signed [qsf_pkg::COORD_W-1:0] i_z_coord,
    input  logic                               i_last_point,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [qsf_pkg::COEF_W-1:0]  o_coef_a,
    output logic signed [qsf_pkg::COEF_W-1:0]  o_coef_b,
    output logic signed [qsf_pkg::COEF_W-1:0]  o_coef_c,
    output logic                               o_singular,
    output logic                               o_too_many_points
);

    logic                              w_push, w_pop, w_nonempty;
    qsf_pkg::t_moments                 w_push_data, w_head;
    logic [qsf_pkg::QCNT_W-1:0]        w_q_count;

    // accumulation front end
    qsf_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_z_coord    (i_z_coord),
        .i_last_point (i_last_point),
        .i_q_count    (w_q_count),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // decouples accumulation from the long solve
    qsf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_push_data),
        .i_pop      (w_pop),
        .o_data     (w_head),
        .o_nonempty (w_nonempty),
        .o_count    (w_q_count)
    );

    // normal-equation solver and result register
    qsf_solve u_solve (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_nonempty      (w_nonempty),
        .i_q_data          (w_head),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_coef_a          (o_coef_a),
        .o_coef_b          (o_coef_b),
        .o_coef_c          (o_coef_c),
        .o_singular        (o_singular),
        .o_too_many_points (o_too_many_points)
    );

endmodule
